### design/jst_pkg.sv
// Shared types and constants for the job slot table.
package jst_pkg;

  localparam int DEF_SLOTS = 256;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 22;
  localparam int NUM_W   = 16;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 2'd0,
    OP_FIND_NUM = 2'd1,
    OP_FIND_KEY = 2'd2,
    OP_REMOVE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [NUM_W-1:0] num;
    logic             bg;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic bad_key;
    logic found;
    logic exhausted;
  } status_t;

endpackage

### design/jst_in_if.sv
// Request channel: operation beat with key, job number and background flag.
interface jst_in_if;
  logic                         valid;
  logic                         ready;
  jst_pkg::op_t                 op;
  logic [jst_pkg::KEY_W-1:0]    group_key;
  logic [jst_pkg::NUM_W-1:0]    job_number;
  logic                         background;

  modport source (output valid, op, group_key, job_number, background, input ready);
  modport sink   (input valid, op, group_key, job_number, background, output ready);
endinterface

### design/jst_out_if.sv
// Result channel: one beat per request with hit, entry and table status.
interface jst_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [jst_pkg::SLOT_W-1:0]    slot_index;
  logic [jst_pkg::NUM_W-1:0]     entry_number;
  logic [jst_pkg::KEY_W-1:0]     entry_key;
  logic                          entry_background;
  logic [jst_pkg::NUM_W-1:0]     current_number;
  logic [jst_pkg::NUM_W-1:0]     previous_number;
  logic [jst_pkg::COUNT_W-1:0]   live_count;

  modport source (output valid, hit, slot_index, entry_number, entry_key, entry_background,
                  current_number, previous_number, live_count, input ready);
  modport sink   (input valid, hit, slot_index, entry_number, entry_key, entry_background,
                  current_number, previous_number, live_count, output ready);
endinterface

### design/jst_ctrl.sv
// Slot table sequencer: accept, scan unless bad_key, commit into result register.
module jst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  jst_pkg::status_t  st,
  output jst_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = st.bad_key ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.found || st.exhausted) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/jst_dp.sv
// Slot storage, scan pipeline, job numbering and result register.
module jst_dp #(
  parameter int SLOTS = jst_pkg::DEF_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  jst_pkg::cmd_t                 cmd,
  output jst_pkg::status_t              st,
  input  jst_pkg::op_t                  in_op,
  input  logic [jst_pkg::KEY_W-1:0]     in_key,
  input  logic [jst_pkg::NUM_W-1:0]     in_num,
  input  logic                          in_bg,
  output logic                          out_hit,
  output logic [jst_pkg::SLOT_W-1:0]    out_slot,
  output logic [jst_pkg::NUM_W-1:0]     out_entry_num,
  output logic [jst_pkg::KEY_W-1:0]     out_entry_key,
  output logic                          out_entry_bg,
  output logic [jst_pkg::NUM_W-1:0]     out_cur,
  output logic [jst_pkg::NUM_W-1:0]     out_prev,
  output logic [jst_pkg::COUNT_W-1:0]   out_count
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  jst_pkg::entry_t mem [SLOTS];

  logic [SLOTS-1:0]           valid_r;
  jst_pkg::op_t               op_r;
  logic [jst_pkg::KEY_W-1:0]  key_r;
  logic [jst_pkg::NUM_W-1:0]  num_r;
  logic                       bg_r;

  logic [IDX_W-1:0]           idx_r;
  logic                       issued_all_r;
  logic                       pv_r;
  logic [IDX_W-1:0]           idx_q_r;
  logic                       vq_r;
  jst_pkg::entry_t            rd_r;

  logic                       hit_r;
  logic [IDX_W-1:0]           slot_r;
  jst_pkg::entry_t            ent_r;

  logic [jst_pkg::NUM_W-1:0]  next_num_r, next_num_nxt;
  logic [jst_pkg::NUM_W-1:0]  cur_r, cur_nxt;
  logic [jst_pkg::NUM_W-1:0]  prev_r, prev_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [SLOTS-1:0]           valid_nxt;

  logic                       match;
  logic                       add_hit, rem_hit;
  jst_pkg::entry_t            new_ent;

  assign new_ent = '{key: key_r, num: next_num_r, bg: bg_r};

  always_comb begin
    unique case (op_r)
      jst_pkg::OP_ADD:      match = !vq_r;
      jst_pkg::OP_FIND_NUM: match = vq_r && (rd_r.num == num_r);
      jst_pkg::OP_FIND_KEY: match = vq_r && (rd_r.key == key_r);
      jst_pkg::OP_REMOVE:   match = vq_r && (rd_r.num == num_r);
      default:              match = 1'b0;
    endcase
  end

  assign st.bad_key   = ((in_op == jst_pkg::OP_ADD) || (in_op == jst_pkg::OP_FIND_KEY))
                        && (in_key == '0);
  assign st.found     = pv_r && match;
  assign st.exhausted = pv_r && !match && (idx_q_r == LAST_IDX);

  assign add_hit = cmd.commit && hit_r && (op_r == jst_pkg::OP_ADD);
  assign rem_hit = cmd.commit && hit_r && (op_r == jst_pkg::OP_REMOVE);

  always_comb begin
    next_num_nxt = next_num_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    cnt_nxt      = cnt_r;
    valid_nxt    = valid_r;
    if (add_hit) begin
      next_num_nxt     = (next_num_r == '1) ? jst_pkg::NUM_W'(1) : next_num_r + 1'b1;
      prev_nxt         = cur_r;
      cur_nxt          = next_num_r;
      cnt_nxt          = cnt_r + 1'b1;
      valid_nxt[slot_r] = 1'b1;
    end else if (rem_hit) begin
      cnt_nxt          = cnt_r - 1'b1;
      valid_nxt[slot_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && !issued_all_r) begin
      rd_r <= mem[idx_r];
    end
    if (add_hit) begin
      mem[slot_r] <= new_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      next_num_r   <= jst_pkg::NUM_W'(1);
      cur_r        <= '0;
      prev_r       <= '0;
      cnt_r        <= '0;
      pv_r         <= 1'b0;
      issued_all_r <= 1'b0;
      hit_r        <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      next_num_r <= next_num_nxt;
      cur_r      <= cur_nxt;
      prev_r     <= prev_nxt;
      cnt_r      <= cnt_nxt;
      if (cmd.load) begin
        pv_r         <= 1'b0;
        issued_all_r <= 1'b0;
        hit_r        <= 1'b0;
      end else if (cmd.scan) begin
        pv_r <= !issued_all_r;
        if (idx_r == LAST_IDX) begin
          issued_all_r <= 1'b1;
        end
        if (st.found) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      key_r  <= in_key;
      num_r  <= in_num;
      bg_r   <= in_bg;
      idx_r  <= '0;
      slot_r <= '0;
      ent_r  <= '0;
    end else if (cmd.scan) begin
      if (!issued_all_r) begin
        idx_q_r <= idx_r;
        vq_r    <= valid_r[idx_r];
        if (idx_r != LAST_IDX) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (st.found) begin
        slot_r <= idx_q_r;
        ent_r  <= (op_r == jst_pkg::OP_ADD) ? new_ent : rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit       <= hit_r;
      out_slot      <= jst_pkg::SLOT_W'(slot_r);
      out_entry_num <= ent_r.num;
      out_entry_key <= ent_r.key;
      out_entry_bg  <= ent_r.bg;
      out_cur       <= cur_nxt;
      out_prev      <= prev_nxt;
      out_count     <= jst_pkg::COUNT_W'(cnt_nxt);
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(cnt_r))
    else $error("live count differs from occupied slots");

  a_next_num_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_num_r != '0)
    else $error("job number zero about to be handed out");

  a_add_hit_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    add_hit |-> (key_r != '0) && !valid_r[slot_r])
    else $error("add placed into an occupied slot or with a zero key");

  a_add_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
    add_hit |=> valid_r[$past(slot_r)])
    else $error("added slot not marked occupied");

  a_remove_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
    rem_hit |=> !valid_r[$past(slot_r)])
    else $error("removed slot still marked occupied");

endmodule

### design/job_slot_table.sv
// Job slot table top level: request and result channels around sequencer and storage.
// Each request beat yields exactly one result beat. An add or a key lookup with a zero
// key skips the scan and goes straight to commit; any other request scans the slots
// lowest first, one slot per cycle through the registered read port of the slot
// memory, and stops at the first match or after the last slot. Occupancy lives in one
// flag per slot cleared by reset, so the table is usable right after reset with no
// clearing pass. A finished result sits in the output register while the next request
// is accepted and scanned; the commit of that next result waits for it to be taken.
module job_slot_table #(
  parameter int SLOTS = jst_pkg::DEF_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  jst_in_if.sink     in_ch,
  jst_out_if.source  out_ch
);

  jst_pkg::cmd_t    cmd;
  jst_pkg::status_t st;

  jst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  jst_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_op         (in_ch.op),
    .in_key        (in_ch.group_key),
    .in_num        (in_ch.job_number),
    .in_bg         (in_ch.background),
    .out_hit       (out_ch.hit),
    .out_slot      (out_ch.slot_index),
    .out_entry_num (out_ch.entry_number),
    .out_entry_key (out_ch.entry_key),
    .out_entry_bg  (out_ch.entry_background),
    .out_cur       (out_ch.current_number),
    .out_prev      (out_ch.previous_number),
    .out_count     (out_ch.live_count)
  );

endmodule
